### rtl/frc8_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frc8_pkg
// types, constants and the crc-8 fold shared by the packet receiver modules
// ----------------------------------------------------------------------------
package frc8_pkg;

  localparam int StoreDepthDefault = 64;

  localparam logic [7:0] StartByte = 8'h00;
  localparam logic [7:0] CrcPoly   = 8'h8C;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_LEN     = 2'd1,
    PH_COLLECT = 2'd2
  } phase_e;

  typedef enum logic {
    KIND_DATA  = 1'b0,
    KIND_ERROR = 1'b1
  } kind_e;

  typedef struct packed {
    logic       valid;
    logic       err;
    logic [7:0] count;
  } emit_cmd_t;

  // reflected crc-8, one byte folded in
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/frc8_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frc8_store
// packet byte store, one write port and one registered read port
// ----------------------------------------------------------------------------
module frc8_store #(
  parameter int STORE_DEPTH = 64,
  localparam int AW = $clog2(STORE_DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem [STORE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

### rtl/frc8_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frc8_emit
// drains a checked packet from the store, or sends the error result,
// through the output register
// ----------------------------------------------------------------------------
module frc8_emit
  import frc8_pkg::*;
#(
  parameter int STORE_DEPTH = 64,
  localparam int AW = $clog2(STORE_DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire emit_cmd_t     cmd_i,
  output logic               busy_o,
  output logic               out_free_o,
  output logic               re_o,
  output logic      [AW-1:0] raddr_o,
  input  wire logic [7:0]    rdata_i,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic      [7:0]    m_axis_tdata,  // out_byte
  output logic               m_axis_tuser,  // result_kind
  output logic               m_axis_tlast   // last_flag
);

  logic [7:0]    rem_q, rem_d;
  logic [AW-1:0] addr_q, addr_d;
  logic          pend_q, pend_d;
  logic          pend_last_q, pend_last_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_data_q, out_data_d;
  logic          out_kind_q, out_kind_d;
  logic          out_last_q, out_last_d;
  logic          issue;

  assign issue = (rem_q != 8'd0) && !pend_q && (!out_valid_q || m_axis_tready);

  always_comb begin
    rem_d       = rem_q;
    addr_d      = addr_q;
    pend_d      = issue;
    pend_last_d = pend_last_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (issue) begin
      rem_d       = rem_q - 8'd1;
      addr_d      = addr_q + AW'(1);
      pend_last_d = (rem_q == 8'd1);
    end
    if (pend_q) begin
      out_valid_d = 1'b1;
      out_data_d  = rdata_i;
      out_kind_d  = KIND_DATA;
      out_last_d  = pend_last_q;
    end
    if (cmd_i.valid) begin
      if (cmd_i.err) begin
        out_valid_d = 1'b1;
        out_data_d  = 8'd0;
        out_kind_d  = KIND_ERROR;
        out_last_d  = 1'b1;
      end else begin
        rem_d  = cmd_i.count;
        addr_d = AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= 8'd0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    pend_last_q <= pend_last_d;
    out_data_q  <= out_data_d;
    out_kind_q  <= out_kind_d;
    out_last_q  <= out_last_d;
  end

  assign busy_o        = (rem_q != 8'd0) || pend_q;
  assign out_free_o    = !out_valid_q;
  assign re_o          = issue;
  assign raddr_o       = addr_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
  a_pend_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !out_valid_q)
    else $error("read data returns while output register is occupied");

  a_pend_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |=> out_valid_q)
    else $error("read data was not loaded into the output register");

  a_cmd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.valid |-> (!busy_o && !out_valid_q))
    else $error("emit command while a burst is running");

  a_error_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KIND_ERROR) |-> (out_last_q && out_data_q == 8'd0))
    else $error("error result is not a final zero byte");
`endif

endmodule
`default_nettype wire

### rtl/framed_packet_receiver_crc8_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// framed_packet_receiver_crc8_top
// framed packet receiver with reflected crc-8 check and store-and-forward
// ----------------------------------------------------------------------------
// Takes one 9-bit link symbol (tdata byte, tuser mark) per transfer. While a
// packet is being received a symbol is taken every cycle unless held off as
// below; the data bytes are written into an internal byte store of STORE_DEPTH
// entries. When the crc byte checks good, the stored bytes (up to
// STORE_DEPTH-1) leave on the master side through the registered store read,
// then the output register, a new read starting only once the last byte is in
// it; tlast marks the final byte. A bad crc gives one error result. Input
// transfers are held off while a burst is read out, and a crc byte waits until
// the output register is free. The store needs no clearing after reset.
module framed_packet_receiver_crc8_top
  import frc8_pkg::*;
#(
  parameter int STORE_DEPTH = StoreDepthDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // symbol_byte
  input  wire logic       s_axis_tuser,   // mark_bit
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic      [7:0] m_axis_tdata,   // out_byte
  output logic            m_axis_tuser,   // result_kind
  output logic            m_axis_tlast    // last_flag
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [7:0] MaxCount = 8'(STORE_DEPTH - 1);
  localparam logic [8:0] DepthLim = 9'(STORE_DEPTH);

  phase_e     phase_q, phase_d;
  logic [7:0] fill_q, fill_d;
  logic [7:0] len_q, len_d;
  logic [7:0] crc_q, crc_d;

  logic          accept;
  logic          at_crc;
  logic          emit_busy;
  logic          out_free;
  logic [8:0]    slot;
  logic          we;
  logic          re;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  emit_cmd_t     cmd;

  assign at_crc        = (phase_q == PH_COLLECT) && (fill_q >= len_q);
  assign s_axis_tready = !emit_busy && !(at_crc && !out_free);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign slot          = {1'b0, fill_q} + 9'd1;

  // next state
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (s_axis_tuser && s_axis_tdata == StartByte) begin
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          phase_d = (!s_axis_tuser && s_axis_tdata != 8'd0) ? PH_COLLECT : PH_IDLE;
        end
        PH_COLLECT: begin
          if (at_crc) begin
            phase_d = PH_IDLE;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  // datapath and outputs
  always_comb begin
    fill_d    = fill_q;
    len_d     = len_q;
    crc_d     = crc_q;
    we        = 1'b0;
    cmd.valid = 1'b0;
    cmd.err   = 1'b0;
    cmd.count = (len_q > MaxCount) ? MaxCount : len_q;
    if (accept) begin
      unique case (phase_q)
        PH_LEN: begin
          if (!s_axis_tuser && s_axis_tdata != 8'd0) begin
            len_d  = s_axis_tdata;
            fill_d = 8'd0;
            crc_d  = crc8_fold(8'd0, s_axis_tdata);
          end
        end
        PH_COLLECT: begin
          if (!at_crc) begin
            we     = (slot < DepthLim);
            crc_d  = crc8_fold(crc_q, s_axis_tdata);
            fill_d = fill_q + 8'd1;
          end else begin
            cmd.valid = 1'b1;
            cmd.err   = (crc8_fold(crc_q, s_axis_tdata) != 8'd0);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      fill_q  <= 8'd0;
      len_q   <= 8'd0;
      crc_q   <= 8'd0;
    end else begin
      phase_q <= phase_d;
      fill_q  <= fill_d;
      len_q   <= len_d;
      crc_q   <= crc_d;
    end
  end

  frc8_store #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (slot[AW-1:0]),
    .wdata_i (s_axis_tdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  frc8_emit #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .busy_o        (emit_busy),
    .out_free_o    (out_free),
    .re_o          (re),
    .raddr_o       (raddr),
    .rdata_i       (rdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire
